// ----- rtl/ordc_pkg.sv -----
// ordc_pkg: shared widths, codes and the result word type for the
// order relation closure unit
// no dependencies

package ordc_pkg;

	localparam int ACT_W = 2;
	localparam int IDX_W = 5;
	localparam int ST_W = 2;
	localparam int CNT_W = 6;
	localparam int ROW_CAP = 32;
	localparam int DEF_MAX_ELEMENTS = 32;
	localparam int RESET_COUNT = 32;

	localparam logic [ACT_W-1:0] ACT_RECORD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_COMPARE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_QUESTION = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_KNOWN = 2'd1;
	localparam logic [ST_W-1:0] ST_REJECT = 2'd2;
	localparam logic [ST_W-1:0] ST_ALL_KNOWN = 2'd3;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic             relation_known;
		logic             first_is_greater;
		logic [IDX_W-1:0] question_first;
		logic [IDX_W-1:0] question_second;
	} result_t;

endpackage

// ----- rtl/ordc_row_mem.sv -----
// ordc_row_mem: relation matrix storage, one row per element, one read and
// one write port, registered read, per-row valid bits for clear
// depends on ordc_pkg only through the parameters handed down

module ordc_row_mem #(
	parameter int ROWS = ordc_pkg::ROW_CAP,
	parameter int ROW_W = $clog2(ordc_pkg::ROW_CAP)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic [ROW_W-1:0] rd_addr,
	output logic [ROWS-1:0]  rd_data,
	input  logic             wr_en,
	input  logic [ROW_W-1:0] wr_addr,
	input  logic [ROWS-1:0]  wr_data
);

	logic [ROWS-1:0] mem [ROWS];
	logic [ROWS-1:0] valid_q;
	logic [ROWS-1:0] rd_mem_q;
	logic            rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_mem_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr] & ~clear;
			if (clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// rows never written since the last clear read as no relations
	assign rd_data = rd_vld_q ? rd_mem_q : '0;

endmodule

// ----- rtl/ordc_count_bank.sv -----
// ordc_count_bank: per-element known-relation counters, bulk update from a
// row of fresh relations, one read port
// depends on ordc_pkg

module ordc_count_bank #(
	parameter int ROWS = ordc_pkg::ROW_CAP,
	parameter int ROW_W = $clog2(ordc_pkg::ROW_CAP)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  logic                       upd_en,
	input  logic [ROW_W-1:0]           upd_row,
	input  logic [ROWS-1:0]            upd_fresh,
	input  logic [ROW_W-1:0]           rd_idx,
	output logic [ordc_pkg::CNT_W-1:0] rd_count
);

	logic [ordc_pkg::CNT_W-1:0] count_q [ROWS];
	logic [ordc_pkg::CNT_W-1:0] pop;

	assign pop = ordc_pkg::CNT_W'($countones(upd_fresh));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < ROWS; b++) begin
				count_q[b] <= '0;
			end
		end else if (clear) begin
			for (int b = 0; b < ROWS; b++) begin
				count_q[b] <= '0;
			end
		end else if (upd_en) begin
			for (int b = 0; b < ROWS; b++) begin
				count_q[b] <= count_q[b] + ordc_pkg::CNT_W'(upd_fresh[b])
					+ ((ROW_W'(b) == upd_row) ? pop : '0);
			end
		end
	end

	assign rd_count = count_q[rd_idx];

endmodule

// ----- rtl/ordc_seq.sv -----
// ordc_seq: item sequencer, row sweeps over the matrix memory for record,
// pair lookup for compare, count and row scans for next question
// depends on ordc_pkg

module ordc_seq #(
	parameter int ROWS = ordc_pkg::ROW_CAP,
	parameter int ROW_W = $clog2(ordc_pkg::ROW_CAP)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ordc_pkg::CNT_W-1:0] n_active,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [ordc_pkg::ACT_W-1:0] action,
	input  logic [ordc_pkg::IDX_W-1:0] first_elem,
	input  logic [ordc_pkg::IDX_W-1:0] second_elem,
	output logic [ROW_W-1:0]           mem_rd_addr,
	input  logic [ROWS-1:0]            mem_rd_data,
	output logic                       mem_wr_en,
	output logic [ROW_W-1:0]           mem_wr_addr,
	output logic [ROWS-1:0]            mem_wr_data,
	output logic                       cnt_upd_en,
	output logic [ROW_W-1:0]           cnt_upd_row,
	output logic [ROWS-1:0]            cnt_upd_fresh,
	output logic [ROW_W-1:0]           cnt_rd_idx,
	input  logic [ordc_pkg::CNT_W-1:0] cnt_rd_data,
	output logic                       res_valid,
	output ordc_pkg::result_t          res,
	input  logic                       res_take
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROW_F,
		S_EVAL,
		S_SWEEP,
		S_MIN,
		S_CHECK,
		S_BEST_ROW,
		S_PSCAN,
		S_DONE
	} state_t;

	state_t                     state_q;
	logic [ordc_pkg::ACT_W-1:0] act_q;
	logic [ROW_W-1:0]           f_q;
	logic [ROW_W-1:0]           s_q;
	logic [ROWS-1:0]            row_s_q;
	logic [ROWS-1:0]            below_q;
	logic [ROWS-1:0]            row_best_q;
	logic [ROW_W-1:0]           ctr_q;
	logic [ROW_W-1:0]           best_q;
	logic [ordc_pkg::CNT_W-1:0] bestcnt_q;
	logic [ROW_W-1:0]           partner_q;
	logic [ordc_pkg::CNT_W-1:0] pcnt_q;
	logic                       found_q;
	ordc_pkg::result_t          res_q;

	logic                       accept;
	logic                       valid_pair;
	logic                       last;
	logic                       sweep_upd;
	logic [ROWS-1:0]            fresh;
	logic                       pair_known;
	logic                       take_partner;
	logic                       gt_fs;
	logic                       gt_sf;

	assign accept = req_valid & ~req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign valid_pair = ({1'b0, first_elem} < n_active) && ({1'b0, second_elem} < n_active)
		&& (first_elem != second_elem);
	assign last = (ordc_pkg::CNT_W'(ctr_q) == n_active - ordc_pkg::CNT_W'(1));

	assign gt_fs = mem_rd_data[s_q];
	assign gt_sf = row_s_q[f_q];

	// rows at or above first take every element at or below second
	assign sweep_upd = (ctr_q == f_q) || mem_rd_data[f_q];
	assign fresh = sweep_upd ? (below_q & ~mem_rd_data) : '0;

	assign pair_known = (ctr_q == best_q) || row_best_q[ctr_q] || mem_rd_data[best_q];
	assign take_partner = ~pair_known && (~found_q || (cnt_rd_data < pcnt_q));

	always_comb begin
		case (state_q)
			S_IDLE:     mem_rd_addr = second_elem[ROW_W-1:0];
			S_ROW_F:    mem_rd_addr = f_q;
			S_CHECK:    mem_rd_addr = best_q;
			S_SWEEP:    mem_rd_addr = ctr_q + ROW_W'(1);
			S_PSCAN:    mem_rd_addr = ctr_q + ROW_W'(1);
			default:    mem_rd_addr = '0;
		endcase
	end

	assign mem_wr_en = (state_q == S_SWEEP) && sweep_upd;
	assign mem_wr_addr = ctr_q;
	assign mem_wr_data = mem_rd_data | fresh;
	assign cnt_upd_en = mem_wr_en;
	assign cnt_upd_row = ctr_q;
	assign cnt_upd_fresh = fresh;
	assign cnt_rd_idx = ctr_q;

	assign res_valid = (state_q == S_DONE);
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= '0;
			f_q <= '0;
			s_q <= '0;
			row_s_q <= '0;
			below_q <= '0;
			row_best_q <= '0;
			ctr_q <= '0;
			best_q <= '0;
			bestcnt_q <= '0;
			partner_q <= '0;
			pcnt_q <= '0;
			found_q <= 1'b0;
			res_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q <= action;
						f_q <= first_elem[ROW_W-1:0];
						s_q <= second_elem[ROW_W-1:0];
						res_q <= '{status: ordc_pkg::ST_REJECT, relation_known: 1'b0,
							first_is_greater: 1'b0, question_first: '0,
							question_second: '0};
						ctr_q <= '0;
						case (action)
							ordc_pkg::ACT_RECORD, ordc_pkg::ACT_COMPARE: begin
								state_q <= valid_pair ? S_ROW_F : S_DONE;
							end
							ordc_pkg::ACT_QUESTION: begin
								state_q <= S_MIN;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_ROW_F: begin
					row_s_q <= mem_rd_data;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					ctr_q <= '0;
					if (act_q == ordc_pkg::ACT_COMPARE) begin
						res_q.status <= ordc_pkg::ST_OK;
						res_q.relation_known <= gt_fs | gt_sf;
						res_q.first_is_greater <= gt_fs;
						state_q <= S_DONE;
					end else if (gt_sf) begin
						state_q <= S_DONE;
					end else if (gt_fs) begin
						res_q.status <= ordc_pkg::ST_KNOWN;
						state_q <= S_DONE;
					end else begin
						below_q <= row_s_q | ({{(ROWS-1){1'b0}}, 1'b1} << s_q);
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					ctr_q <= ctr_q + ROW_W'(1);
					if (last) begin
						res_q.status <= ordc_pkg::ST_OK;
						state_q <= S_DONE;
					end
				end
				S_MIN: begin
					if ((ctr_q == '0) || (cnt_rd_data < bestcnt_q)) begin
						best_q <= ctr_q;
						bestcnt_q <= cnt_rd_data;
					end
					ctr_q <= ctr_q + ROW_W'(1);
					if (last) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					found_q <= 1'b0;
					if ((n_active > ordc_pkg::CNT_W'(1))
							&& (bestcnt_q < n_active - ordc_pkg::CNT_W'(1))) begin
						state_q <= S_BEST_ROW;
					end else begin
						res_q.status <= ordc_pkg::ST_ALL_KNOWN;
						state_q <= S_DONE;
					end
				end
				S_BEST_ROW: begin
					row_best_q <= mem_rd_data;
					ctr_q <= '0;
					state_q <= S_PSCAN;
				end
				S_PSCAN: begin
					if (take_partner) begin
						partner_q <= ctr_q;
						pcnt_q <= cnt_rd_data;
						found_q <= 1'b1;
					end
					ctr_q <= ctr_q + ROW_W'(1);
					if (last) begin
						if (found_q || take_partner) begin
							res_q.status <= ordc_pkg::ST_OK;
							res_q.question_first <= ordc_pkg::IDX_W'(best_q);
							res_q.question_second <= take_partner ? ordc_pkg::IDX_W'(ctr_q)
								: ordc_pkg::IDX_W'(partner_q);
						end else begin
							res_q.status <= ordc_pkg::ST_ALL_KNOWN;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_wr_rd_apart: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (mem_wr_addr != mem_rd_addr))
		else $error("row write collides with row read");

	a_no_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> !below_q[f_q])
		else $error("closure sweep would make first below itself");

	a_partner_not_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PSCAN) && found_q |-> (partner_q != best_q))
		else $error("question partner equals chosen element");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && !res_take |=> (state_q == S_DONE) && $stable(res_q))
		else $error("pending result lost before hand-off");

endmodule

// ----- rtl/order_relation_closure_unit.sv -----
// order_relation_closure_unit: top level, element count register, output
// register, matrix memory, counters and sequencer
// depends on ordc_pkg, ordc_row_mem, ordc_count_bank, ordc_seq
//
// channel  direction  handshake               word
// cfg      in         cfg_wr_en               cfg_wr_data (element count)
// req      in         req_valid / req_stall   action, first_elem, second_elem
// rsp      out        rsp_valid / rsp_stall   status, relation_known, first_is_greater,
//                                             question_first, question_second
//
// one word in flight; record sweeps the matrix one row per cycle, question does a
// count scan, then a row scan, compare reads two rows, a rejected word goes to the result
// n is the element count clamped to 1 .. min(MAX_ELEMENTS, 32)
// reset and count writes clear the matrix at once through valid bits, and the counters directly
// a new word is taken while the previous result waits in the output register

module order_relation_closure_unit #(
	parameter int MAX_ELEMENTS = ordc_pkg::DEF_MAX_ELEMENTS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ordc_pkg::CNT_W-1:0] cfg_wr_data,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [ordc_pkg::ACT_W-1:0] action,
	input  logic [ordc_pkg::IDX_W-1:0] first_elem,
	input  logic [ordc_pkg::IDX_W-1:0] second_elem,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [ordc_pkg::ST_W-1:0]  status,
	output logic                       relation_known,
	output logic                       first_is_greater,
	output logic [ordc_pkg::IDX_W-1:0] question_first,
	output logic [ordc_pkg::IDX_W-1:0] question_second
);

	localparam int ROWS = (MAX_ELEMENTS < ordc_pkg::ROW_CAP) ? MAX_ELEMENTS : ordc_pkg::ROW_CAP;
	localparam int ROW_W = $clog2(ROWS);
	localparam int N_RESET = (ordc_pkg::RESET_COUNT < ROWS) ? ordc_pkg::RESET_COUNT : ROWS;

	logic [ordc_pkg::CNT_W-1:0] n_q;
	logic [ordc_pkg::CNT_W-1:0] n_clamped;
	logic                       rsp_valid_q;
	ordc_pkg::result_t          rsp_q;

	logic [ROW_W-1:0]           mem_rd_addr;
	logic [ROWS-1:0]            mem_rd_data;
	logic                       mem_wr_en;
	logic [ROW_W-1:0]           mem_wr_addr;
	logic [ROWS-1:0]            mem_wr_data;
	logic                       cnt_upd_en;
	logic [ROW_W-1:0]           cnt_upd_row;
	logic [ROWS-1:0]            cnt_upd_fresh;
	logic [ROW_W-1:0]           cnt_rd_idx;
	logic [ordc_pkg::CNT_W-1:0] cnt_rd_data;
	logic                       res_valid;
	ordc_pkg::result_t          res;
	logic                       res_take;

	always_comb begin
		if (cfg_wr_data == '0) begin
			n_clamped = ordc_pkg::CNT_W'(1);
		end else if (cfg_wr_data > ordc_pkg::CNT_W'(ROWS)) begin
			n_clamped = ordc_pkg::CNT_W'(ROWS);
		end else begin
			n_clamped = cfg_wr_data;
		end
	end

	assign res_take = res_valid & (~rsp_valid_q | ~rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= ordc_pkg::CNT_W'(N_RESET);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				n_q <= n_clamped;
			end
			if (res_take) begin
				rsp_valid_q <= 1'b1;
			end else if (~rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = rsp_q.status;
	assign relation_known = rsp_q.relation_known;
	assign first_is_greater = rsp_q.first_is_greater;
	assign question_first = rsp_q.question_first;
	assign question_second = rsp_q.question_second;

	ordc_row_mem #(
		.ROWS  (ROWS),
		.ROW_W (ROW_W)
	) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (cfg_wr_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	ordc_count_bank #(
		.ROWS  (ROWS),
		.ROW_W (ROW_W)
	) u_count_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (cfg_wr_en),
		.upd_en    (cnt_upd_en),
		.upd_row   (cnt_upd_row),
		.upd_fresh (cnt_upd_fresh),
		.rd_idx    (cnt_rd_idx),
		.rd_count  (cnt_rd_data)
	);

	ordc_seq #(
		.ROWS  (ROWS),
		.ROW_W (ROW_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.n_active      (n_q),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.action        (action),
		.first_elem    (first_elem),
		.second_elem   (second_elem),
		.mem_rd_addr   (mem_rd_addr),
		.mem_rd_data   (mem_rd_data),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_addr   (mem_wr_addr),
		.mem_wr_data   (mem_wr_data),
		.cnt_upd_en    (cnt_upd_en),
		.cnt_upd_row   (cnt_upd_row),
		.cnt_upd_fresh (cnt_upd_fresh),
		.cnt_rd_idx    (cnt_rd_idx),
		.cnt_rd_data   (cnt_rd_data),
		.res_valid     (res_valid),
		.res           (res),
		.res_take      (res_take)
	);

endmodule
